>>> sv/stair_wave_fade_sequencer_top_defines.svh
// Assertion macros for the stair wave fade sequencer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STAIR_WAVE_FADE_SEQUENCER_TOP_DEFINES_SVH
`define STAIR_WAVE_FADE_SEQUENCER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/swfs_pkg.sv
// Shared types, codes and constants for the stair wave fade sequencer.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package swfs_pkg;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int CH_W     = 5;
  localparam int DUTY_W   = 22;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 6;
  localparam int DUTYC_W  = 16;
  localparam int INC_W    = 12;
  localparam int WW_W     = 12;
  localparam int RAMP_W   = 20;
  localparam int CALC_W   = 23;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  // Parameter defaults and limits
  localparam int MAX_STAIRS_DEF = 32;
  localparam int RESULT_LIMIT   = 32;

  // Command modes
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ON    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_IDLE     = 2'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING  = 2'd1;
  localparam logic [STAT_W-1:0] ST_DONE_ON  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE_OFF = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STAIR_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DUTY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_WIDTH  = 3'd4;

  // Register reset values
  localparam logic [CNT_W-1:0]   RST_STAIR_COUNT = 6'd16;
  localparam logic [DUTYC_W-1:0] RST_MIN_DUTY    = 16'd0;
  localparam logic [DUTYC_W-1:0] RST_MAX_DUTY    = 16'hFFFF;
  localparam logic [INC_W-1:0]   RST_RAMP_INC    = 12'd64;
  localparam logic [WW_W-1:0]    RST_WAVE_WIDTH  = 12'd256;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic prep;      // latch base duty and stair count for a running tick
    logic emit;      // load the next stair result into the output register
    logic emit_off;  // load the single off result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic running;   // a ramp is in progress
    logic at_last;   // current stair is the last of this tick
    logic out_free;  // output register can take a result this cycle
  } dp_stat_t;

endpackage

>>> sv/stair_wave_fade_sequencer_top.sv
// Stair wave fade sequencer top level: stream ports, configuration port,
// controller and datapath (swfs_ctrl, swfs_datapath, swfs_pkg).
// Start and stop produce no result; an idle tick loads its single off result from
// the off state; a running tick of n stairs passes the prepare state, then loads
// its n results. Throughput: one result a cycle while the output is not stalled;
// no command is taken until a tick is done. Reset: synchronous, registers to defaults.
`timescale 1ns / 1ps

module stair_wave_fade_sequencer_top
  import swfs_pkg::*;
#(
  parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] direction, [7:1] zero
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] channel, [26:5] raw_duty,
                                            // [28:27] status, [31:29] zero
  output logic                  out_tlast   // last result of the tick
);

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [CH_W-1:0]   out_channel;
  logic [DUTY_W-1:0] out_raw_duty;
  logic [STAT_W-1:0] out_status;

  // The user must write registers only while idle; the block does not enforce it, so always take the write
  assign cfg_ready = 1'b1;

  swfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_mode   (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  swfs_datapath #(
    .MAX_STAIRS (MAX_STAIRS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mode      (in_tuser),
    .in_direction (in_tdata[0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_channel  (out_channel),
    .out_raw_duty (out_raw_duty),
    .out_status   (out_status),
    .out_last     (out_tlast)
  );

  // Pack result fields, lowest first
  assign out_tdata = OUT_DATA_W'({out_status, out_raw_duty, out_channel});

endmodule

>>> sv/swfs_ctrl.sv
// Controller state machine of the stair wave fade sequencer.
// Depends on swfs_pkg; drives commands to swfs_datapath and reads its status.
`timescale 1ns / 1ps

module swfs_ctrl
  import swfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [MODE_W-1:0] in_mode,
  input  dp_stat_t          stat,
  output dp_cmd_t           cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PREP = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_OFF  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Sequence commands: take a command, then prepare and walk the stairs, or emit the off result for an idle tick
  always_comb begin
    state_nxt    = state_r;
    cmd.accept   = accept;
    cmd.prep     = 1'b0;
    cmd.emit     = 1'b0;
    cmd.emit_off = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_TICK) begin
          state_nxt = stat.running ? S_PREP : S_OFF;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.at_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OFF: begin
        if (stat.out_free) begin
          cmd.emit_off = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/swfs_datapath.sv
// Datapath of the stair wave fade sequencer: registers, ramp state, duty
// arithmetic and the output register. Depends on swfs_pkg; driven by swfs_ctrl.
`timescale 1ns / 1ps

module swfs_datapath
  import swfs_pkg::*;
#(
  parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic                  in_direction,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [CH_W-1:0]       out_channel,
  output logic [DUTY_W-1:0]     out_raw_duty,
  output logic [STAT_W-1:0]     out_status,
  output logic                  out_last
);

  localparam int LIM   = (MAX_STAIRS < RESULT_LIMIT) ? MAX_STAIRS : RESULT_LIMIT;
  localparam int IDX_W = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int LAG_W = WW_W + IDX_W;

  // Configuration registers
  logic [CNT_W-1:0]   stair_count_r;
  logic [DUTYC_W-1:0] min_duty_r;
  logic [DUTYC_W-1:0] max_duty_r;
  logic [INC_W-1:0]   ramp_inc_r;
  logic [WW_W-1:0]    wave_width_r;

  // Ramp state
  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic              dir_r, dir_nxt;
  logic              on_r, on_nxt;
  logic              running_r, running_nxt;

  // Per-tick walk
  logic [CALC_W-1:0] base_r;
  logic [LAG_W-1:0]  lag_r;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  last_idx_r;

  // Output register
  logic              oval_r, oval_nxt;
  logic [CH_W-1:0]   och_r;
  logic [DUTY_W-1:0] oduty_r;
  logic [STAT_W-1:0] ostat_r;
  logic              olast_r;

  logic [RAMP_W:0]     ramp_sum;
  logic [CNT_W:0]      n_clamp;
  logic [CALC_W-1:0]   base_nxt;
  logic [CALC_W-1:0]   duty;
  logic [IDX_W-1:0]    ch_idx;
  logic [STAT_W-1:0]   final_stat;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stair_count_r <= RST_STAIR_COUNT;
      min_duty_r    <= RST_MIN_DUTY;
      max_duty_r    <= RST_MAX_DUTY;
      ramp_inc_r    <= RST_RAMP_INC;
      wave_width_r  <= RST_WAVE_WIDTH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STAIR_COUNT: stair_count_r <= cfg_data[CNT_W-1:0];
        REG_MIN_DUTY:    min_duty_r    <= cfg_data[DUTYC_W-1:0];
        REG_MAX_DUTY:    max_duty_r    <= cfg_data[DUTYC_W-1:0];
        REG_RAMP_INC:    ramp_inc_r    <= cfg_data[INC_W-1:0];
        REG_WAVE_WIDTH:  wave_width_r  <= cfg_data[WW_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating ramp advance
  assign ramp_sum = {1'b0, ramp_r} + (RAMP_W + 1)'(ramp_inc_r);

  // Clamp stair count to one .. LIM
  always_comb begin
    if (stair_count_r == '0) begin
      n_clamp = (CNT_W + 1)'(1);
    end else if ((CNT_W + 1)'(stair_count_r) > (CNT_W + 1)'(LIM)) begin
      n_clamp = (CNT_W + 1)'(LIM);
    end else begin
      n_clamp = (CNT_W + 1)'(stair_count_r);
    end
  end

  // Base duty: ramp plus offset on turn-on, full minus ramp on turn-off
  assign base_nxt = on_r ? (CALC_W'(ramp_r) + CALC_W'(min_duty_r))
                         : (CALC_W'(max_duty_r) - CALC_W'(ramp_r));

  // Duty of the current stair, and the end test on the last one
  assign duty   = on_r ? (base_r - CALC_W'(lag_r)) : (base_r + CALC_W'(lag_r));
  assign ch_idx = dir_r ? (last_idx_r - idx_r) : idx_r;

  always_comb begin
    final_stat = ST_RUNNING;
    if (on_r && ($signed(duty) >= $signed(CALC_W'(max_duty_r)))) begin
      final_stat = ST_DONE_ON;
    end else if (!on_r && duty[CALC_W-1]) begin
      final_stat = ST_DONE_OFF;
    end
  end

  // Ramp state updates from commands and the end of a ramp
  always_comb begin
    ramp_nxt    = ramp_r;
    dir_nxt     = dir_r;
    on_nxt      = on_r;
    running_nxt = running_r;
    if (cmd.accept) begin
      case (in_mode)
        MODE_ON, MODE_OFF: begin
          dir_nxt     = in_direction;
          ramp_nxt    = '0;
          on_nxt      = (in_mode == MODE_ON);
          running_nxt = 1'b1;
        end
        MODE_STOP: begin
          running_nxt = 1'b0;
          ramp_nxt    = '0;
        end
        MODE_TICK: begin
          if (running_r) begin
            ramp_nxt = ramp_sum[RAMP_W] ? '1 : ramp_sum[RAMP_W-1:0];
          end
        end
        default: ;
      endcase
    end
    if (cmd.emit && stat.at_last && final_stat != ST_RUNNING) begin
      running_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r    <= '0;
      dir_r     <= 1'b0;
      on_r      <= 1'b0;
      running_r <= 1'b0;
    end else begin
      ramp_r    <= ramp_nxt;
      dir_r     <= dir_nxt;
      on_r      <= on_nxt;
      running_r <= running_nxt;
    end
  end

  // Stair walk: prepare once, then advance index and lag per result
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      base_r     <= base_nxt;
      last_idx_r <= IDX_W'(n_clamp - (CNT_W + 1)'(1));
      idx_r      <= '0;
      lag_r      <= '0;
    end else if (cmd.emit) begin
      idx_r <= idx_r + IDX_W'(1);
      lag_r <= lag_r + LAG_W'(wave_width_r);
    end
  end

  // Output register: hold while stalled, reload when free
  always_comb begin
    oval_nxt = oval_r;
    if (cmd.emit || cmd.emit_off) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      och_r   <= CH_W'(ch_idx);
      oduty_r <= duty[DUTY_W-1:0];
      ostat_r <= stat.at_last ? final_stat : ST_RUNNING;
      olast_r <= stat.at_last;
    end else if (cmd.emit_off) begin
      och_r   <= '0;
      oduty_r <= '0;
      ostat_r <= ST_IDLE;
      olast_r <= 1'b1;
    end
  end

  assign stat.running  = running_r;
  assign stat.at_last  = (idx_r == last_idx_r);
  assign stat.out_free = !oval_r || out_tready;

  assign out_tvalid   = oval_r;
  assign out_channel  = och_r;
  assign out_raw_duty = oduty_r;
  assign out_status   = ostat_r;
  assign out_last     = olast_r;

endmodule

>>> sv/swfs_checker.sv
// Port-level assertion checker for the stair wave fade sequencer, bound to
// the top level. Depends on swfs_pkg and the top level's defines header.
`timescale 1ns / 1ps
`include "stair_wave_fade_sequencer_top_defines.svh"

module swfs_checker
  import swfs_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // A stalled result holds its payload
  `SWFS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")

  // Every result before the last of a tick reports running
  `SWFS_ASSERT_NOW(a_mid_running, out_tvalid && !out_tlast,
    out_tdata[28:27] == ST_RUNNING, "non-final result without running status")

  // An off result stands alone with zero channel and duty
  `SWFS_ASSERT_NOW(a_off_form, out_tvalid && out_tdata[28:27] == ST_IDLE,
    out_tlast && out_tdata[26:0] == 27'd0, "malformed off result")

  // No new command is taken while a tick still has stairs to emit
  `SWFS_ASSERT_NOW(a_busy_walk, out_tvalid && !out_tlast,
    !in_tready, "input taken in the middle of a stair walk")

endmodule

bind stair_wave_fade_sequencer_top swfs_checker u_swfs_checker (.*);

>>> tb/swfs_duty_checker.sv
// Duty checker for the stair wave fade sequencer: watches the configuration,
// command and result channels, predicts every duty and compares in order.
// Depends on swfs_pkg for widths, modes, status codes and register indexes.
`timescale 1ns / 1ps

module swfs_duty_checker
  import swfs_pkg::*;
#(
  parameter int MAX_STAIRS = MAX_STAIRS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [0] direction, [7:1] zero
  input  logic [MODE_W-1:0]     in_tuser,   // [1:0] mode
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] channel, [26:5] raw_duty,
                                            // [28:27] status, [31:29] zero
  input  logic                  out_tlast,
  output int                    duties_pending,
  output int                    mismatch_count
);

  localparam int STAIR_LIMIT = (MAX_STAIRS < RESULT_LIMIT) ? MAX_STAIRS : RESULT_LIMIT;
  localparam logic [RAMP_W-1:0] RAMP_CEIL = {RAMP_W{1'b1}};

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [DUTY_W-1:0] raw_duty;
    logic [STAT_W-1:0] status;
    logic              last;
  } duty_rec_t;

  // Shadow copy of the registers
  logic [CNT_W-1:0]   stairs_cfg;
  logic [DUTYC_W-1:0] min_cfg;
  logic [DUTYC_W-1:0] max_cfg;
  logic [INC_W-1:0]   inc_cfg;
  logic [WW_W-1:0]    wave_cfg;

  // Shadow copy of the ramp state
  logic [RAMP_W-1:0] ramp;
  logic              sweep_up;
  logic              turning_on;
  logic              ramping;

  duty_rec_t duty_queue[$];
  int        mismatches;

  // Advance the ramp state for one command and queue the duties it causes
  task automatic predict_duties(input logic [MODE_W-1:0] mode, input logic dir);
    int          n;
    longint      lag;
    longint      duty;
    logic [RAMP_W:0] ramp_sum;
    duty_rec_t   rec;
    case (mode)
      MODE_ON, MODE_OFF: begin
        sweep_up   = dir;
        ramp       = '0;
        turning_on = (mode == MODE_ON);
        ramping    = 1'b1;
      end
      MODE_STOP: begin
        ramping = 1'b0;
        ramp    = '0;
      end
      MODE_TICK: begin
        if (!ramping) begin
          rec = '{channel: '0, raw_duty: '0, status: ST_IDLE, last: 1'b1};
          duty_queue.push_back(rec);
        end else begin
          n = int'(stairs_cfg);
          if (n < 1) n = 1;
          if (n > STAIR_LIMIT) n = STAIR_LIMIT;
          // Saturate the ramp counter
          ramp_sum = {1'b0, ramp} + inc_cfg;
          ramp = (ramp_sum > {1'b0, RAMP_CEIL}) ? RAMP_CEIL : ramp_sum[RAMP_W-1:0];
          duty = 0;
          for (int i = 0; i < n; i++) begin
            lag = longint'(wave_cfg) * i;
            if (turning_on) duty = longint'(ramp) + longint'(min_cfg) - lag;
            else            duty = longint'(max_cfg) - (longint'(ramp) - lag);
            rec.channel  = sweep_up ? CH_W'(n - 1 - i) : CH_W'(i);
            rec.raw_duty = duty[DUTY_W-1:0];
            rec.status   = ST_RUNNING;
            rec.last     = 1'b0;
            if (i == n - 1) begin
              rec.last = 1'b1;
              if (turning_on && duty >= longint'(max_cfg)) begin
                ramping    = 1'b0;
                rec.status = ST_DONE_ON;
              end else if (!turning_on && duty < 0) begin
                ramping    = 1'b0;
                rec.status = ST_DONE_OFF;
              end
            end
            duty_queue.push_back(rec);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    duty_rec_t want;
    duty_rec_t got;
    if (!rst_n) begin
      stairs_cfg = RST_STAIR_COUNT;
      min_cfg    = RST_MIN_DUTY;
      max_cfg    = RST_MAX_DUTY;
      inc_cfg    = RST_RAMP_INC;
      wave_cfg   = RST_WAVE_WIDTH;
      ramp       = '0;
      sweep_up   = 1'b0;
      turning_on = 1'b0;
      ramping    = 1'b0;
      mismatches = 0;
      duty_queue.delete();
    end else begin
      // Compare a result transaction with the oldest expectation
      if (out_tvalid && out_tready) begin
        got.channel  = out_tdata[CH_W-1:0];
        got.raw_duty = out_tdata[CH_W +: DUTY_W];
        got.status   = out_tdata[CH_W+DUTY_W +: STAT_W];
        got.last     = out_tlast;
        if (duty_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ch=%0d duty=%h status=%0d last=%0b",
                     $realtime, got.channel, got.raw_duty, got.status, got.last);
        end else begin
          want = duty_queue.pop_front();
          if (got.channel !== want.channel || got.raw_duty !== want.raw_duty ||
              got.status !== want.status || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result differs: expected ch=%0d duty=%h status=%0d last=%0b, got ch=%0d duty=%h status=%0d last=%0b",
                       $realtime, want.channel, want.raw_duty, want.status, want.last,
                       got.channel, got.raw_duty, got.status, got.last);
          end
        end
      end
      // Track register writes; unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STAIR_COUNT: stairs_cfg = cfg_data[CNT_W-1:0];
          REG_MIN_DUTY:    min_cfg    = cfg_data[DUTYC_W-1:0];
          REG_MAX_DUTY:    max_cfg    = cfg_data[DUTYC_W-1:0];
          REG_RAMP_INC:    inc_cfg    = cfg_data[INC_W-1:0];
          REG_WAVE_WIDTH:  wave_cfg   = cfg_data[WW_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_duties(in_tuser, in_tdata[0]);
    end
    duties_pending <= duty_queue.size();
    mismatch_count <= mismatches;
  end

endmodule

>>> tb/tb_stair_wave_fade_sequencer_top.sv
// Testbench top for the stair wave fade sequencer: clock, reset, commands,
// register settings and back-pressure; swfs_duty_checker does the checking.
// Depends on swfs_pkg, stair_wave_fade_sequencer_top and swfs_duty_checker.
`timescale 1ns / 1ps

module tb_stair_wave_fade_sequencer_top;
  import swfs_pkg::*;

  localparam int STAIRS         = MAX_STAIRS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [0] direction, [7:1] zero
  logic [MODE_W-1:0]     in_tuser   = '0;  // [1:0] mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [4:0] channel, [26:5] raw_duty,
                                           // [28:27] status, [31:29] zero
  logic                  out_tlast;

  int duties_pending;
  int mismatch_count;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles;

  always #4 clk = ~clk;

  stair_wave_fade_sequencer_top #(.MAX_STAIRS(STAIRS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  swfs_duty_checker #(.MAX_STAIRS(STAIRS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast),
    .duties_pending(duties_pending), .mismatch_count(mismatch_count)
  );

  // Receiver: random back-pressure, one long hold-off on request
  always @(posedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 20);
    end
  end

  // Offer one command transaction, with an occasional gap before it
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic dir);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_DATA_W'(dir);
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the sender until every expected duty has come, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (duties_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all five registers back to back, optionally the unused indexes too
  task automatic load_settings(input int stairs, input int lo, input int hi,
                               input int step, input int lag, input bit spare);
    logic [CFG_IDX_W-1:0]  idxs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    idxs = '{REG_STAIR_COUNT, REG_MIN_DUTY, REG_MAX_DUTY, REG_RAMP_INC, REG_WAVE_WIDTH};
    vals = '{CFG_DATA_W'(stairs), CFG_DATA_W'(lo), CFG_DATA_W'(hi),
             CFG_DATA_W'(step), CFG_DATA_W'(lag)};
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idxs[k];
      cfg_data  <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    if (spare) begin
      for (int k = int'(REG_WAVE_WIDTH) + 1; k < (1 << CFG_IDX_W); k++) begin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(k);
        cfg_data  <= CFG_DATA_W'($urandom_range(0, 65535));
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // Watchdog: end the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int sent;
    int ticks;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: idle ticks, a slow ramp each way, stop, idle again
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_ON, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_OFF, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_STOP, 1'b0);
    send_item(MODE_TICK, 1'b0);
    drain_results();

    // Fast ramps that finish on the first tick, both ways
    load_settings(4, 0, 1000, 4095, 100, 1'b1);
    send_item(MODE_ON, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_OFF, 1'b1);
    send_item(MODE_TICK, 1'b0);
    drain_results();

    // Top extremes: stair count above the limit, restart while running
    load_settings(63, 65535, 65535, 4095, 4095, 1'b0);
    send_item(MODE_ON, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_OFF, 1'b0);
    send_item(MODE_TICK, 1'b1);
    send_item(MODE_STOP, 1'b1);
    drain_results();

    // Bottom extremes: zero stair count, zero increment
    load_settings(0, 0, 0, 0, 0, 1'b0);
    send_item(MODE_ON, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_OFF, 1'b1);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_TICK, 1'b0);
    send_item(MODE_STOP, 1'b0);

    // Random phases: mostly a start followed by a run of ticks, some noise
    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      load_settings(($urandom_range(0, 99) < 70) ? $urandom_range(1, 8) : $urandom_range(0, 63),
                    $urandom_range(0, 65535), $urandom_range(0, 65535),
                    ($urandom_range(0, 99) < 80) ? $urandom_range(1024, 4095)
                                                 : $urandom_range(0, 4095),
                    $urandom_range(0, 4095), 1'b0);
      calm = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < 14) begin
        if ($urandom_range(0, 99) < 80) begin
          send_item($urandom_range(0, 1) ? MODE_ON : MODE_OFF, 1'($urandom_range(0, 1)));
          sent++;
          ticks = $urandom_range(1, 24);
          repeat (ticks) begin
            send_item(($urandom_range(0, 19) == 0) ? MODE_STOP : MODE_TICK,
                      1'($urandom_range(0, 1)));
            sent++;
          end
        end else begin
          send_item(MODE_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
    calm = 1'b0;

    // Let the last duties arrive, then give the verdict
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && duties_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> stair_wave_fade_sequencer_top.f
+incdir+sv
sv/swfs_pkg.sv
sv/swfs_ctrl.sv
sv/swfs_datapath.sv
sv/stair_wave_fade_sequencer_top.sv
sv/swfs_checker.sv
tb/swfs_duty_checker.sv
tb/tb_stair_wave_fade_sequencer_top.sv
